// File: hdl/sgf_pkg.sv
// Shared constants, register codes and types for the Scharr gradient filter.
`timescale 1ns / 1ps
`default_nettype none

package sgf_pkg;

  // Line store depth and derived address width
  localparam int MAX_WIDTH = 2048;
  localparam int ADDR_W    = $clog2(MAX_WIDTH);

  // Field widths
  localparam int PIX_W   = 8;
  localparam int GRAD_W  = 13;
  localparam int COL_W   = 11;
  localparam int ROW_W   = 12;
  localparam int CFG_W   = 12;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  // Register reset values and lower and upper limits
  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [CFG_W-1:0] DIM_MIN      = 12'd3;
  localparam logic [CFG_W-1:0] WIDTH_MAX    = CFG_W'(MAX_WIDTH);

  // Gradient magnitude limit for 8-bit samples
  localparam logic signed [GRAD_W-1:0] GRAD_LIMIT = 13'sd4080;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  // One result item
  typedef struct packed {
    logic              frame_last;
    logic [ROW_W-1:0]  center_row;
    logic [COL_W-1:0]  center_col;
    logic [GRAD_W-1:0] grad_vertical;
    logic [GRAD_W-1:0] grad_horizontal;
  } out_item_t;

  // Control carried from the address stage into the compute stage
  typedef struct packed {
    logic              emit;
    logic              last;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  pix;
  } stage_ctl_t;

endpackage

`default_nettype wire

// File: hdl/sgf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sgf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hdl/scharr_gradient_filter.sv
// Top level of the Scharr 3x3 gradient filter.
//
// Usage: 8-bit grayscale pixels enter on the in_ stream in raster order, one
// item per pixel; the first pixel after reset or after a frame's last pixel
// starts a frame. Frame size comes from the cfg_ port (index 0 width, index 1
// height); the user must write it only while the block is idle; the block
// does not enforce this. For every interior pixel one item leaves on the out_
// stream: both gradients (signed 13-bit integers), center column and row, and
// tlast on the frame's last interior pixel. Border pixels produce no item.
// Order: the result for a pixel is formed once the pixel that lies below and
// to the right of it is accepted (RAM read, then compute into the output
// queue). Throughput: 1 pixel per cycle while in_tready is high, set by the
// single line-store RAM that is read and written once per item.
// A 3-entry output queue decouples the sides: in_tready drops only when the
// queue plus the item in compute would overflow, so a stalled receiver backs
// up the input in turn.
// Reset clears the counters, window, queue and registers (640 x 480); line
// store contents stay undefined; unwritten entries never reach a result.
`timescale 1ns / 1ps
`default_nettype none

module scharr_gradient_filter
  import sgf_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream, tdata: pixel_value[7:0]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // result stream, tdata: grad_horizontal[12:0], grad_vertical[25:13],
  // center_col[36:26], center_row[48:37], zero fill[55:49]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic                        out_tlast,
  // configuration write port
  input  wire logic                   cfg_we,
  input  wire logic [0:0]             cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_wdata
);

  localparam int QDEPTH = 3;

  // Configuration registers
  logic [CFG_W-1:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective frame size with limits applied
  logic [CFG_W-1:0] eff_w, eff_h, w_m1, h_m1;

  always_comb begin
    eff_w = frame_width_r;
    if (frame_width_r < DIM_MIN) eff_w = DIM_MIN;
    else if (frame_width_r > WIDTH_MAX) eff_w = WIDTH_MAX;
    eff_h = (frame_height_r < DIM_MIN) ? DIM_MIN : frame_height_r;
    w_m1  = eff_w - 12'd1;
    h_m1  = eff_h - 12'd1;
  end

  // Handshake and queue state
  logic             in_acc;
  logic [1:0]       q_cnt_r, q_cnt_nxt;
  logic [1:0]       q_wr_r, q_rd_r;
  logic             q_push, q_pop;
  logic             s1_valid_r;
  stage_ctl_t       s1_r, s1_nxt;

  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = ({1'b0, q_cnt_r} + {2'b00, s1_valid_r}) <= 3'd2;

  // Position counters, advanced on each accepted pixel
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CFG_W-1:0] col_ext;

  assign col_ext = {1'b0, col_r};

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      if (col_ext + 12'd1 >= eff_w) begin
        col_nxt = '0;
        row_nxt = ({1'b0, row_r} + 13'd1 >= {1'b0, eff_h}) ? '0 : row_r + 12'd1;
      end else begin
        col_nxt = col_r + 11'd1;
      end
    end
  end

  // Address stage: classify the position and capture the pixel
  always_comb begin
    s1_nxt.emit = (col_r >= 11'd2) && (col_ext <= w_m1)
               && (row_r >= 12'd2) && (row_r <= h_m1);
    s1_nxt.last = (col_ext == w_m1) && (row_r == h_m1);
    s1_nxt.col  = col_r - 11'd1;
    s1_nxt.row  = row_r - 12'd1;
    s1_nxt.addr = col_r[ADDR_W-1:0];
    s1_nxt.pix  = in_tdata[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Line store: one RAM, entry = {middle row, upper row}. Read at accept,
  // written back in the next cycle; the same column comes back no sooner than
  // three items later, so no forwarding is needed.
  logic [2*PIX_W-1:0] ls_rdata, ls_wdata;
  logic [PIX_W-1:0]   top, mid, bot;

  assign top      = ls_rdata[PIX_W-1:0];
  assign mid      = ls_rdata[2*PIX_W-1:PIX_W];
  assign bot      = s1_r.pix;
  assign ls_wdata = {bot, mid};

  sgf_ram #(
    .WIDTH (2*PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_r.addr),
    .wdata (ls_wdata),
    .re    (in_acc),
    .raddr (s1_nxt.addr),
    .rdata (ls_rdata)
  );

  // Window: [0..2] column c-2 (top, mid, bottom), [3..5] column c-1
  logic [PIX_W-1:0] win_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) win_r[i] <= '0;
    end else if (s1_valid_r) begin
      win_r[0] <= win_r[3];
      win_r[1] <= win_r[4];
      win_r[2] <= win_r[5];
      win_r[3] <= top;
      win_r[4] <= mid;
      win_r[5] <= bot;
    end
  end

  // Kernel sums; differences are scaled by 3 and 10 with shifts and adds
  logic signed [13:0] dx0, dx1, dx2, dy0, dy1, dy2, gx, gy;

  always_comb begin
    dx0 = $signed({6'd0, top})      - $signed({6'd0, win_r[0]});
    dx1 = $signed({6'd0, mid})      - $signed({6'd0, win_r[1]});
    dx2 = $signed({6'd0, bot})      - $signed({6'd0, win_r[2]});
    dy0 = $signed({6'd0, win_r[2]}) - $signed({6'd0, win_r[0]});
    dy1 = $signed({6'd0, win_r[5]}) - $signed({6'd0, win_r[3]});
    dy2 = $signed({6'd0, bot})      - $signed({6'd0, top});
    gx  = (dx0 <<< 1) + dx0 + (dx1 <<< 3) + (dx1 <<< 1) + (dx2 <<< 1) + dx2;
    gy  = (dy0 <<< 1) + dy0 + (dy1 <<< 3) + (dy1 <<< 1) + (dy2 <<< 1) + dy2;
  end

  out_item_t res;

  assign res.grad_horizontal = gx[GRAD_W-1:0];
  assign res.grad_vertical   = gy[GRAD_W-1:0];
  assign res.center_col      = s1_r.col;
  assign res.center_row      = s1_r.row;
  assign res.frame_last      = s1_r.last;

  // Output queue
  out_item_t q_mem_r [QDEPTH];

  assign q_push = s1_valid_r && s1_r.emit;
  assign q_pop  = out_tvalid && out_tready;

  always_comb begin
    q_cnt_nxt = q_cnt_r;
    case ({q_push, q_pop})
      2'b10:   q_cnt_nxt = q_cnt_r + 2'd1;
      2'b01:   q_cnt_nxt = q_cnt_r - 2'd1;
      default: q_cnt_nxt = q_cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= '0;
      q_wr_r  <= '0;
      q_rd_r  <= '0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
      if (q_push) q_wr_r <= (q_wr_r == 2'(QDEPTH - 1)) ? 2'd0 : q_wr_r + 2'd1;
      if (q_pop)  q_rd_r <= (q_rd_r == 2'(QDEPTH - 1)) ? 2'd0 : q_rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem_r[q_wr_r] <= res;
    end
  end

  // Result port
  out_item_t q_head;

  assign q_head     = q_mem_r[q_rd_r];
  assign out_tvalid = (q_cnt_r != 2'd0);
  assign out_tlast  = q_head.frame_last;
  assign out_tdata  = {7'd0, q_head.center_row, q_head.center_col,
                       q_head.grad_vertical, q_head.grad_horizontal};

endmodule

`default_nettype wire

// File: hdl/sgf_checker.sv
// Port-level checks for the Scharr gradient filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sgf_checker
  import sgf_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tlast,
  input wire logic                   cfg_we,
  input wire logic [0:0]             cfg_index,
  input wire logic [CFG_W-1:0]       cfg_wdata
);

  // Queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  // An empty output side never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output queue");

  // Results are interior pixels with gradients inside the 8-bit bound
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[36:26] != '0 && out_tdata[48:37] != '0
      && $signed(out_tdata[12:0]) <= GRAD_LIMIT
      && $signed(out_tdata[12:0]) >= -GRAD_LIMIT
      && $signed(out_tdata[25:13]) <= GRAD_LIMIT
      && $signed(out_tdata[25:13]) >= -GRAD_LIMIT)
    else $error("result outside interior or gradient bound");

endmodule

bind scharr_gradient_filter sgf_checker u_sgf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .cfg_we     (cfg_we),
  .cfg_index  (cfg_index),
  .cfg_wdata  (cfg_wdata)
);

`default_nettype wire

// File: sim/tb_scharr_gradient_filter.sv
// Self-checking testbench for the Scharr gradient filter: directed frames, big frames, random frames.
`timescale 1ns / 1ps

module tb_scharr_gradient_filter;
  import sgf_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 4;
  localparam int RANDOM_ITEMS = 650;
  localparam int QUIET_ITEMS  = 100;

  // Full-scale gradients for 8-bit samples
  localparam logic [GRAD_W-1:0] GRAD_POS_FULL = GRAD_LIMIT;
  localparam logic [GRAD_W-1:0] GRAD_NEG_FULL = -GRAD_LIMIT;

  typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_e;
  typedef enum int {MIX_UNIFORM, MIX_EXTREME, MIX_FLAT} pixel_mix_e;

  typedef struct packed {
    step_kind_e        kind;
    reg_index_t        index;
    logic [CFG_W-1:0]  value;
    logic              check;
    out_item_t         want;
  } dir_step_t;

  // Directed frames. Result fields in order: frame_last, center_row, center_col,
  // grad_vertical, grad_horizontal.
  localparam int NUM_DIRECTED = 30;
  localparam dir_step_t DIRECTED [NUM_DIRECTED] = '{
    // cut the power-on geometry mid-row; height below the minimum acts as 3
    '{STEP_CFG,   REG_FRAME_WIDTH,  12'd4,   1'b0, '0},
    '{STEP_CFG,   REG_FRAME_HEIGHT, 12'd2,   1'b0, '0},
    // rest of the cut row lies outside the new frame: no result
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'h055, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'h0aa, 1'b0, '0},
    // 4x3 frame, columns 255,0,0,255: full negative then full positive x gradient
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b1,
      '{1'b0, 12'd1, 11'd1, 13'd0, GRAD_NEG_FULL}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b1,
      '{1'b1, 12'd1, 11'd2, 13'd0, GRAD_POS_FULL}},
    // width below the minimum acts as 3; 3x4 frame, rows 255,0,0,255
    '{STEP_CFG,   REG_FRAME_WIDTH,  12'd2,   1'b0, '0},
    '{STEP_CFG,   REG_FRAME_HEIGHT, 12'd4,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd0,   1'b1,
      '{1'b0, 12'd1, 11'd1, GRAD_NEG_FULL, 13'd0}},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b0, '0},
    '{STEP_PIXEL, REG_FRAME_WIDTH,  12'd255, 1'b1,
      '{1'b1, 12'd2, 11'd1, GRAD_POS_FULL, 13'd0}}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we;
  reg_index_t             cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  // Gradient predictor state
  logic [PIX_W-1:0] upper_line [MAX_WIDTH];
  logic [PIX_W-1:0] middle_line [MAX_WIDTH];
  logic [PIX_W-1:0] win [6];
  int               col_pos;
  int               row_pos;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  out_item_t pending_gradients [$];
  int        mismatch_count;
  int        cycle_count;
  int        stall_left;
  bit        tx_idle_on;
  bit        rx_idle_on;

  scharr_gradient_filter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock
  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Width and height in use after clamping
  function automatic int frame_cols(input logic [CFG_W-1:0] v);
    if (v < DIM_MIN) return int'(DIM_MIN);
    if (v > WIDTH_MAX) return MAX_WIDTH;
    return int'(v);
  endfunction

  function automatic int frame_rows(input logic [CFG_W-1:0] v);
    return (v < DIM_MIN) ? int'(DIM_MIN) : int'(v);
  endfunction

  // Advance the filter by one pixel; returns 1 when an interior result is due
  function automatic bit predict_gradient(input logic [PIX_W-1:0] pix,
                                          output out_item_t res);
    int w, h, c, r;
    int top, mid, bot, a0, a1, a2, b0, b2, gx, gy;
    bit hit;
    w   = frame_cols(width_reg);
    h   = frame_rows(height_reg);
    c   = col_pos;
    r   = row_pos;
    top = upper_line[c];
    mid = middle_line[c];
    bot = pix;
    hit = c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1;
    res = '0;
    if (hit) begin
      a0 = win[0];
      a1 = win[1];
      a2 = win[2];
      b0 = win[3];
      b2 = win[5];
      gx = 3 * (top - a0) + 10 * (mid - a1) + 3 * (bot - a2);
      gy = 3 * (a2 - a0) + 10 * (b2 - b0) + 3 * (bot - top);
      res.grad_horizontal = gx[GRAD_W-1:0];
      res.grad_vertical   = gy[GRAD_W-1:0];
      res.center_col      = COL_W'(c - 1);
      res.center_row      = ROW_W'(r - 1);
      res.frame_last      = (c == w - 1 && r == h - 1);
    end
    // shift window one column left, bring in the new column
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = PIX_W'(top);
    win[4] = PIX_W'(mid);
    win[5] = pix;
    upper_line[c]  = PIX_W'(mid);
    middle_line[c] = pix;
    // raster counters
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
    return hit;
  endfunction

  // Offer one pixel, with an optional hold-off burst; predict once accepted
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic typed,
                            input out_item_t typed_result);
    out_item_t predicted;
    int        gap;
    bit        hit;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    do @(posedge clk); while (!in_tready);
    hit = predict_gradient(pix, predicted);
    if (typed) begin
      pending_gradients.push_back(typed_result);
    end else if (hit) begin
      pending_gradients.push_back(predicted);
    end
  endtask

  // Wait until every expected result is out, then let the pipeline settle
  task automatic wait_for_drain();
    while (pending_gradients.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val;
    end else begin
      height_reg = val;
    end
  endtask

  // Set the geometry while idle, then stream count pixels of the given mix
  task automatic run_frames(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                            input int count, input pixel_mix_e mix);
    logic [PIX_W-1:0] pix;
    in_tvalid <= 1'b0;
    wait_for_drain();
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    repeat (count) begin
      case (mix)
        MIX_EXTREME: pix = $urandom_range(0, 1) ? 8'hff : 8'h00;
        MIX_FLAT:    pix = PIX_W'($urandom_range(100, 140));
        default:     pix = PIX_W'($urandom_range(0, 255));
      endcase
      send_pixel(pix, 1'b0, '0);
    end
  endtask

  // Result checker and receiver stall bursts
  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tlast, out_tdata[$bits(out_item_t)-2:0]};
      if (pending_gradients.size() == 0) begin
        mismatch_count++;
        $error("result item with none expected: col %0d row %0d",
               got.center_col, got.center_row);
      end else begin
        want = pending_gradients.pop_front();
        if (got.grad_horizontal !== want.grad_horizontal) begin
          mismatch_count++;
          $error("grad_horizontal: expected %0d, got %0d",
                 $signed(want.grad_horizontal), $signed(got.grad_horizontal));
        end
        if (got.grad_vertical !== want.grad_vertical) begin
          mismatch_count++;
          $error("grad_vertical: expected %0d, got %0d",
                 $signed(want.grad_vertical), $signed(got.grad_vertical));
        end
        if (got.center_col !== want.center_col) begin
          mismatch_count++;
          $error("center_col: expected %0d, got %0d", want.center_col, got.center_col);
        end
        if (got.center_row !== want.center_row) begin
          mismatch_count++;
          $error("center_row: expected %0d, got %0d", want.center_row, got.center_row);
        end
        if (got.frame_last !== want.frame_last) begin
          mismatch_count++;
          $error("frame_last: expected %0d, got %0d", want.frame_last, got.frame_last);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_scharr_gradient_filter failed");
    $finish;
  end

  // Stimulus
  initial begin
    logic [CFG_W-1:0] new_w;
    logic [CFG_W-1:0] new_h;
    int               frame_len;
    int               count;
    int               random_sent;
    bit               quiet;
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = REG_FRAME_WIDTH;
    cfg_wdata      = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    stall_left     = 0;
    random_sent    = 0;
    tx_idle_on     = 1'b1;
    rx_idle_on     = 1'b1;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      upper_line[i]  = '0;
      middle_line[i] = '0;
    end
    for (int i = 0; i < 6; i++) win[i] = '0;
    col_pos    = 0;
    row_pos    = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Power-on geometry: three rows of 640 and a bit into the fourth
    repeat (3 * int'(WIDTH_RESET) + 2) begin
      send_pixel(PIX_W'($urandom_range(0, 255)), 1'b0, '0);
    end

    // Directed table
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (DIRECTED[i].kind == STEP_CFG) begin
        in_tvalid <= 1'b0;
        wait_for_drain();
        write_reg(DIRECTED[i].index, DIRECTED[i].value);
      end else begin
        send_pixel(DIRECTED[i].value[PIX_W-1:0], DIRECTED[i].check, DIRECTED[i].want);
      end
    end

    // Largest frames: width above the line store clamps to its depth
    run_frames(12'd4095, 12'd3, MAX_WIDTH * 3, MIX_UNIFORM);
    run_frames(12'd3, 12'd4095, 3 * 4095, MIX_UNIFORM);

    // Random geometries, whole and partial frames, some changes mid-frame
    while (random_sent < RANDOM_ITEMS) begin
      quiet      = random_sent >= RANDOM_ITEMS - QUIET_ITEMS;
      tx_idle_on = !quiet && $urandom_range(0, 3) != 0;
      rx_idle_on = !quiet && $urandom_range(0, 3) != 0;
      new_w = ($urandom_range(0, 15) == 0) ? CFG_W'($urandom_range(13, 40))
                                           : CFG_W'($urandom_range(0, 10));
      // growing the width past row 0 would read line store entries never written
      if (row_pos != 0 && frame_cols(new_w) > frame_cols(width_reg)) begin
        new_w = CFG_W'($urandom_range(0, frame_cols(width_reg)));
      end
      new_h     = CFG_W'($urandom_range(0, 8));
      frame_len = frame_cols(new_w) * frame_rows(new_h);
      count     = ($urandom_range(0, 2) == 0) ? $urandom_range(1, frame_len)
                                              : frame_len * $urandom_range(1, 2);
      run_frames(new_w, new_h, count, pixel_mix_e'($urandom_range(0, 2)));
      random_sent += count;
    end

    in_tvalid <= 1'b0;
    wait_for_drain();
    if (mismatch_count == 0 && pending_gradients.size() == 0) begin
      $display("tb_scharr_gradient_filter passed");
    end else begin
      $display("tb_scharr_gradient_filter failed");
    end
    $finish;
  end

endmodule
